[rtl/bpc_pkg.sv]
package bpc_pkg;

    localparam int KEY_W      = 2;
    localparam int TIME_W     = 32;
    localparam int LONG_W     = 16;
    localparam int MARGIN_W   = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int NUM_KEYS_DEF = 4;

    typedef logic [1:0]        kind_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [2:0]        ev_t;
    typedef logic [1:0]        status_t;
    typedef logic [TIME_W-1:0] time_t;

    // item kinds
    localparam kind_t KIND_EDGE  = 2'd0;
    localparam kind_t KIND_POLL  = 2'd1;
    localparam kind_t KIND_CLEAR = 2'd2;
    localparam kind_t KIND_QUERY = 2'd3;

    // result events
    localparam ev_t EV_PUSH      = 3'd0;
    localparam ev_t EV_SHORT     = 3'd1;
    localparam ev_t EV_LONG_REL  = 3'd2;
    localparam ev_t EV_RELEASE   = 3'd3;
    localparam ev_t EV_LONG_PUSH = 3'd4;
    localparam ev_t EV_EXCEPTION = 3'd5;
    localparam ev_t EV_REPORT    = 3'd6;

    // key status
    localparam status_t ST_NONE      = 2'd0;
    localparam status_t ST_SHORT     = 2'd1;
    localparam status_t ST_LONG_PUSH = 2'd2;
    localparam status_t ST_LONG_REL  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_MARGIN = 1'b1;

    localparam logic [LONG_W-1:0]   LONG_PRESS_RST  = 16'd2000;
    localparam logic [MARGIN_W-1:0] POLL_MARGIN_RST = 8'd10;

    // per-key state as seen on the read port
    typedef struct packed {
        logic    pushed;
        logic    released;
        status_t status;
        time_t   start;
    } bpc_key_t;

    // write request into the key bank
    typedef struct packed {
        logic    en;
        logic    set_start;
        logic    pushed;
        logic    released;
        status_t status;
    } bpc_wr_t;

    // outcome of the shared time compare
    typedef struct packed {
        logic short_hold;
        logic held;
    } bpc_cmp_t;

endpackage

[rtl/button_press_classifier.sv]
// Button press classifier for NUM_KEYS keys. Each accepted word is an edge, an idle poll,
// a clear or a status query, and gives zero, one or two result words, the final one
// flagged by m_last. Items are handled one at a time: s_ready is high only while the
// sequencer is idle. A poll steps a single 32-bit subtract and compare unit over the
// keys one per cycle. A result word sits in the output register until taken, so the
// next item may be accepted meanwhile. Configuration writes take effect at once and
// should be made while idle.
module button_press_classifier #(
    parameter int NUM_KEYS = bpc_pkg::NUM_KEYS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bpc_pkg::kind_t                      s_kind,
    input  bpc_pkg::key_t                       s_key,
    input  logic                                s_first_level,
    input  logic                                s_second_level,
    input  bpc_pkg::time_t                      s_now_ms,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bpc_pkg::ev_t                        m_event_res,
    output bpc_pkg::key_t                       m_event_key,
    output bpc_pkg::status_t                    m_key_status,
    output logic                                m_last
);
    import bpc_pkg::*;

    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_KEYS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_CLEAR,
        S_EMIT
    } state_t;

    state_t                state_reg;
    kind_t                 kind_reg;
    key_t                  key_reg;
    logic                  l1_reg;
    logic                  l2_reg;
    time_t                 now_reg;
    logic [IDX_W-1:0]      cnt_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      first_reg;
    ev_t                   ev_reg;
    key_t                  ekey_reg;
    status_t               st_reg;
    logic                  two_reg;

    logic                  m_valid_reg;
    ev_t                   m_ev_reg;
    key_t                  m_key_reg;
    status_t               m_st_reg;
    logic                  m_last_reg;

    logic [LONG_W-1:0]     long_press_reg;
    logic [MARGIN_W-1:0]   poll_margin_reg;

    logic                  key_ok;
    logic [IDX_W-1:0]      key_idx;
    logic [IDX_W-1:0]      rd_idx;
    logic                  edge_ok;
    logic                  rel_fire;
    logic                  hit;
    logic                  out_free;
    bpc_key_t              rd;
    bpc_wr_t               wr;
    bpc_cmp_t              cmp;
    status_t               rel_status;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_reg  <= LONG_PRESS_RST;
            poll_margin_reg <= POLL_MARGIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_LONG_PRESS:  long_press_reg  <= cfg_wdata[LONG_W-1:0];
                CFG_POLL_MARGIN: poll_margin_reg <= cfg_wdata[MARGIN_W-1:0];
            endcase
        end
    end

    assign key_ok     = {{(32-KEY_W){1'b0}}, key_reg} < 32'(NUM_KEYS);
    assign key_idx    = IDX_W'(key_reg);
    assign rd_idx     = (state_reg == S_SCAN) ? cnt_reg : key_idx;
    assign edge_ok    = (l1_reg == l2_reg) && key_ok;
    // a low edge ends a press that was pushed or is still in long push
    assign rel_fire   = (rd.pushed && (rd.released || !l1_reg)) || (rd.status == ST_LONG_PUSH);
    assign rel_status = cmp.short_hold ? ST_SHORT : ST_LONG_REL;
    assign hit        = rd.pushed && cmp.held;
    assign out_free   = !m_valid_reg || m_ready;

    bpc_key_bank #(
        .NUM_KEYS (NUM_KEYS),
        .IDX_W    (IDX_W)
    ) u_bank (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .idx      (rd_idx),
        .wr       (wr),
        .wr_start (now_reg),
        .clr      (state_reg == S_CLEAR),
        .rd       (rd)
    );

    bpc_cmp u_cmp (
        .now_ms         (now_reg),
        .start_ms       (rd.start),
        .long_press_ms  (long_press_reg),
        .poll_margin_ms (poll_margin_reg),
        .res            (cmp)
    );

    // key bank update
    always_comb begin
        wr = '0;
        if (state_reg == S_LOOKUP && kind_reg == KIND_EDGE && edge_ok) begin
            if (l1_reg) begin
                wr.en        = 1'b1;
                wr.set_start = 1'b1;
                wr.pushed    = 1'b1;
                wr.released  = rd.released;
                wr.status    = ST_NONE;
            end else if (rel_fire) begin
                wr.en       = 1'b1;
                wr.pushed   = 1'b0;
                wr.released = 1'b0;
                wr.status   = rel_status;
            end
        end else if (state_reg == S_SCAN && hit) begin
            wr.en       = 1'b1;
            wr.pushed   = 1'b0;
            wr.released = rd.released;
            wr.status   = found_reg ? ST_NONE : ST_LONG_PUSH;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
            two_reg     <= 1'b0;
        end else begin
            // while emitting, the emit arm alone drives the output valid
            if (m_ready && state_reg != S_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        kind_reg  <= s_kind;
                        key_reg   <= s_key;
                        l1_reg    <= s_first_level;
                        l2_reg    <= s_second_level;
                        now_reg   <= s_now_ms;
                        cnt_reg   <= '0;
                        found_reg <= 1'b0;
                        unique case (s_kind) inside
                            KIND_EDGE, KIND_QUERY: state_reg <= S_LOOKUP;
                            KIND_POLL:             state_reg <= S_SCAN;
                            KIND_CLEAR:            state_reg <= S_CLEAR;
                        endcase
                    end
                end
                S_LOOKUP: begin
                    ekey_reg <= key_reg;
                    two_reg  <= 1'b0;
                    if (kind_reg == KIND_QUERY) begin
                        ev_reg    <= EV_REPORT;
                        st_reg    <= key_ok ? rd.status : ST_NONE;
                        state_reg <= S_EMIT;
                    end else if (edge_ok && l1_reg) begin
                        ev_reg    <= EV_PUSH;
                        st_reg    <= ST_NONE;
                        state_reg <= S_EMIT;
                    end else if (edge_ok && rel_fire) begin
                        ev_reg    <= cmp.short_hold ? EV_SHORT : EV_LONG_REL;
                        st_reg    <= rel_status;
                        two_reg   <= 1'b1;
                        state_reg <= S_EMIT;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    two_reg <= 1'b0;
                    st_reg  <= ST_LONG_PUSH;
                    if (hit && found_reg) begin
                        // second held key: report the first one and stop
                        ev_reg    <= EV_EXCEPTION;
                        ekey_reg  <= KEY_W'(first_reg);
                        state_reg <= S_EMIT;
                    end else begin
                        if (hit) begin
                            found_reg <= 1'b1;
                            first_reg <= cnt_reg;
                        end
                        if (cnt_reg == LAST_IDX) begin
                            if (found_reg || hit) begin
                                ev_reg    <= EV_LONG_PUSH;
                                ekey_reg  <= found_reg ? KEY_W'(first_reg) : KEY_W'(cnt_reg);
                                state_reg <= S_EMIT;
                            end else begin
                                state_reg <= S_IDLE;
                            end
                        end else begin
                            cnt_reg <= cnt_reg + IDX_W'(1);
                        end
                    end
                end
                S_CLEAR: begin
                    state_reg <= S_IDLE;
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_ev_reg    <= ev_reg;
                        m_key_reg   <= ekey_reg;
                        m_st_reg    <= st_reg;
                        m_last_reg  <= !two_reg;
                        if (two_reg) begin
                            two_reg <= 1'b0;
                            ev_reg  <= EV_RELEASE;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_event_res  = m_ev_reg;
    assign m_event_key  = m_key_reg;
    assign m_key_status = m_st_reg;
    assign m_last       = m_last_reg;

endmodule

[rtl/bpc_cmp.sv]
module bpc_cmp (
    input  bpc_pkg::time_t                   now_ms,
    input  bpc_pkg::time_t                   start_ms,
    input  logic [bpc_pkg::LONG_W-1:0]       long_press_ms,
    input  logic [bpc_pkg::MARGIN_W-1:0]     poll_margin_ms,
    output bpc_pkg::bpc_cmp_t                res
);
    import bpc_pkg::*;

    time_t               spent;
    logic [LONG_W-1:0]   poll_thr;
    logic                margin_over;

    // elapsed time wraps with the millisecond counter
    assign spent       = now_ms - start_ms;
    assign margin_over = {{(LONG_W-MARGIN_W){1'b0}}, poll_margin_ms} > long_press_ms;
    assign poll_thr    = long_press_ms - {{(LONG_W-MARGIN_W){1'b0}}, poll_margin_ms};

    assign res.short_hold = spent < {{(TIME_W-LONG_W){1'b0}}, long_press_ms};
    assign res.held        = margin_over || (spent > {{(TIME_W-LONG_W){1'b0}}, poll_thr});

endmodule

[rtl/bpc_key_bank.sv]
module bpc_key_bank #(
    parameter int NUM_KEYS = bpc_pkg::NUM_KEYS_DEF,
    parameter int IDX_W    = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [IDX_W-1:0]     idx,
    input  bpc_pkg::bpc_wr_t     wr,
    input  bpc_pkg::time_t       wr_start,
    input  logic                 clr,
    output bpc_pkg::bpc_key_t    rd
);
    import bpc_pkg::*;

    logic    pushed_reg   [NUM_KEYS];
    logic    released_reg [NUM_KEYS];
    status_t status_reg   [NUM_KEYS];
    time_t   start_reg    [NUM_KEYS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                pushed_reg[i]   <= 1'b0;
                released_reg[i] <= 1'b0;
                status_reg[i]   <= ST_NONE;
            end
        end else begin
            // clear keeps a key that is still in long push
            if (clr) begin
                for (int i = 0; i < NUM_KEYS; i++) begin
                    if (status_reg[i] != ST_LONG_PUSH) begin
                        status_reg[i] <= ST_NONE;
                    end
                end
            end
            if (wr.en) begin
                pushed_reg[idx]   <= wr.pushed;
                released_reg[idx] <= wr.released;
                status_reg[idx]   <= wr.status;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en && wr.set_start) begin
            start_reg[idx] <= wr_start;
        end
    end

    assign rd.pushed   = pushed_reg[idx];
    assign rd.released = released_reg[idx];
    assign rd.status   = status_reg[idx];
    assign rd.start    = start_reg[idx];

endmodule

[rtl/bpc_checker.sv]
module bpc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input bpc_pkg::ev_t                        m_event_res,
    input bpc_pkg::key_t                       m_event_key,
    input bpc_pkg::status_t                    m_key_status,
    input logic                                m_last
);
    import bpc_pkg::*;

    // one item at a time: ready is low in the cycle after a word is taken
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on two consecutive cycles");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_res) && $stable(m_event_key)
            && $stable(m_key_status) && $stable(m_last))
        else $error("stalled result word changed");

    // short or long release is always followed by release of the same key
    a_rel_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_event_res == EV_SHORT || m_event_res == EV_LONG_REL)
            |=> m_valid && m_event_res == EV_RELEASE && m_last && $stable(m_event_key)
                && $stable(m_key_status))
        else $error("release did not follow its classification");

    a_rel_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == EV_SHORT || m_event_res == EV_LONG_REL)
            |-> !m_last && (m_key_status == ST_SHORT || m_key_status == ST_LONG_REL))
        else $error("classification word with wrong status or last flag");

    a_push: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == EV_LONG_PUSH || m_event_res == EV_EXCEPTION)
            |-> m_last && m_key_status == ST_LONG_PUSH)
        else $error("poll result with wrong status");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (.*);
